/* rtl/core/sis_pkg.sv */
// Package: shared types and constants for the sorted integer set.
`timescale 1ns / 1ps
`default_nettype none
package sis_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int HELD_W   = 7;
  localparam int VAL_W    = 32;

  localparam logic [1:0] ACT_MEMBER = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] key_value;
  } sis_in_t;

  typedef struct packed {
    logic              success;
    logic              store_full;
    logic [HELD_W-1:0] entries_held;
  } sis_out_t;

  typedef struct packed {
    logic load;
    logic ptr_clr;
    logic ptr_inc;
    logic idx_from_cnt;
    logic idx_from_ptr;
    logic idx_inc;
    logic idx_dec;
    logic rd_ptr;
    logic rd_idx_m1;
    logic rd_idx_p1;
    logic wr_shift;
    logic wr_key;
    logic cnt_inc;
    logic cnt_dec;
    logic pres_set;
    logic pres_clr;
    logic done;
    logic res_success;
    logic res_full;
  } sis_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       ptr_at_end;
    logic       lt;
    logic       eq;
    logic       present;
    logic       full;
    logic       idx_at_ptr;
    logic       idx_last;
  } sis_sts_t;

endpackage
`default_nettype wire

/* rtl/core/sis_datapath.sv */
// Datapath: value store, scan pointers, entry count and result register.
`timescale 1ns / 1ps
`default_nettype none
module sis_datapath
  import sis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sis_in_t  in_item,
  input  wire sis_cmd_t cmd,
  output sis_sts_t      sts,
  output logic          out_valid,
  output sis_out_t      out_item
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_r;
  sis_in_t          req_r;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pres_r, pres_nxt;
  logic             vld_r;
  sis_out_t         res_r;
  logic [CNT_W-1:0] idx_m1, idx_p1;
  logic [CNT_W-1:0] rd_addr;
  logic             rd_en;

  assign idx_m1 = idx_r - CNT_W'(1);
  assign idx_p1 = idx_r + CNT_W'(1);

  always_comb begin
    rd_en   = cmd.rd_ptr | cmd.rd_idx_m1 | cmd.rd_idx_p1;
    rd_addr = ptr_r;
    if (cmd.rd_idx_m1) begin
      rd_addr = idx_m1;
    end else if (cmd.rd_idx_p1) begin
      rd_addr = idx_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr[ADDR_W-1:0]];
    end
    if (cmd.wr_shift) begin
      mem[idx_r[ADDR_W-1:0]] <= rd_r;
    end else if (cmd.wr_key) begin
      mem[ptr_r[ADDR_W-1:0]] <= req_r.key_value;
    end
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.done) begin
      res_r.success      <= cmd.res_success;
      res_r.store_full   <= cmd.res_full;
      res_r.entries_held <= HELD_W'(cnt_r);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_from_cnt) begin
      idx_nxt = cnt_r;
    end else if (cmd.idx_from_ptr) begin
      idx_nxt = ptr_r;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_p1;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    pres_nxt = pres_r;
    if (cmd.pres_set) begin
      pres_nxt = sts.eq;
    end else if (cmd.pres_clr) begin
      pres_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    idx_r  <= idx_nxt;
    pres_r <= pres_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= cmd.done;
    end
  end

  always_comb begin
    sts.action     = req_r.action;
    sts.ptr_at_end = (ptr_r == cnt_r);
    sts.lt         = $signed(rd_r) < req_r.key_value;
    sts.eq         = (rd_r == req_r.key_value);
    sts.present    = pres_r;
    sts.full       = (cnt_r == CNT_W'(CAPACITY));
    sts.idx_at_ptr = (idx_r == ptr_r);
    sts.idx_last   = (idx_p1 == cnt_r);
  end

  assign out_valid = vld_r;
  assign out_item  = res_r;

endmodule
`default_nettype wire

/* rtl/core/sis_ctrl.sv */
// Controller: sequences search, shift and result steps for each item.
`timescale 1ns / 1ps
`default_nettype none
module sis_ctrl
  import sis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire sis_sts_t sts,
  output sis_cmd_t      cmd,
  output logic          busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_ICHK = 4'd4;
  localparam logic [3:0] S_IWR  = 4'd5;
  localparam logic [3:0] S_DCHK = 4'd6;
  localparam logic [3:0] S_DWR  = 4'd7;
  localparam logic [3:0] S_OK   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        if (sts.ptr_at_end) begin
          cmd.pres_clr = 1'b1;
          state_nxt    = S_DEC;
        end else begin
          cmd.rd_ptr = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.lt) begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_RD;
        end else begin
          cmd.pres_set = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        unique case (sts.action)
          ACT_MEMBER: begin
            cmd.done        = 1'b1;
            cmd.res_success = sts.present;
          end
          ACT_INSERT: begin
            if (sts.present) begin
              cmd.done = 1'b1;
            end else if (sts.full) begin
              cmd.done     = 1'b1;
              cmd.res_full = 1'b1;
            end else begin
              cmd.idx_from_cnt = 1'b1;
              state_nxt        = S_ICHK;
            end
          end
          ACT_DELETE: begin
            if (sts.present) begin
              cmd.idx_from_ptr = 1'b1;
              state_nxt        = S_DCHK;
            end else begin
              cmd.done = 1'b1;
            end
          end
          default: begin
            cmd.done = 1'b1;
          end
        endcase
      end
      S_ICHK: begin
        if (sts.idx_at_ptr) begin
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_OK;
        end else begin
          cmd.rd_idx_m1 = 1'b1;
          state_nxt     = S_IWR;
        end
      end
      S_IWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = S_ICHK;
      end
      S_DCHK: begin
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_OK;
        end else begin
          cmd.rd_idx_p1 = 1'b1;
          state_nxt     = S_DWR;
        end
      end
      S_DWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_DCHK;
      end
      S_OK: begin
        cmd.done        = 1'b1;
        cmd.res_success = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* rtl/core/sorted_integer_set.sv */
// Top level: ordered set of distinct signed 32-bit values with fixed capacity.
//
// Usage: drive in_item (action, key_value) and raise start; the item is
// taken on a rising edge where start is high and busy is low. busy stays
// high until the item's single result has been issued.
// The result appears on out_item for exactly one cycle with out_valid high;
// the receiver cannot stall it and must take it in that cycle.
// Steps, with n entries held and p the position of the value:
//   search: walks the store one read and one compare per entry passed
//   insert: shifts each entry from p upward up (n - p), delete: shifts
//   each entry above p down (n - p - 1), each a read then a write of the
//   store, plus setup and result steps.
// One item at a time; out_valid is registered from the last step of an
// item and rises in the cycle after it; the next item may be accepted in
// that same cycle.
// Reset (synchronous, active low) empties the set at once; store contents
// are not cleared since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_integer_set
  import sis_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire sis_in_t in_item,
  output logic         out_valid,
  output sis_out_t     out_item
);

  sis_cmd_t cmd;
  sis_sts_t sts;

  sis_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  sis_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
